[hdl/pac_pkg.sv]
// pac_pkg: shared types and constants of the polygon area / right-angle block
// no dependencies; imported by pac_front, pac_back and polygon_area_right_angle
package pac_pkg;

   // geometry and counting limits
   localparam int COORD_BITS   = 16;
   localparam int MAX_VERTICES = 1024;
   localparam int COUNT_BITS   = $clog2(MAX_VERTICES + 1);
   localparam int ACC_BITS     = 43;
   localparam int AREA_BITS    = 42;
   localparam int PROD_BITS    = 2 * COORD_BITS;
   localparam int DIFF_BITS    = COORD_BITS + 1;
   localparam int DOT_BITS     = 2 * DIFF_BITS;
   localparam int TERM_BITS    = PROD_BITS + 2;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = COUNT_BITS'(MAX_VERTICES);
   localparam logic [COUNT_BITS-1:0] COUNT_MIN = COUNT_BITS'(3);

   typedef struct packed {
      logic signed [COORD_BITS-1:0] x;
      logic signed [COORD_BITS-1:0] y;
   } point_type;

   // one classified vertex on its way from front to back
   typedef struct packed {
      point_type              cur;
      point_type              prev;
      point_type              older;
      point_type              first;
      point_type              second;
      logic                   add_cross;   // edge term from previous vertex
      logic                   test_mid;    // angle at previous vertex
      logic                   test_close;  // angles at last and first vertices
      logic                   last;
      logic [COUNT_BITS-1:0]  count;
      logic                   shape_ok;
   } job_type;

   // one finished polygon
   typedef struct packed {
      logic [AREA_BITS-1:0]   area_doubled;
      logic                   has_right_angle;
      logic [COUNT_BITS-1:0]  vertex_count;
      logic                   count_is_even;
      logic                   shape_valid;
   } result_type;

   // queue handshake as seen by a writer
   typedef struct packed {
      logic push;
      logic full;
   } wr_ctl_type;

endpackage

[hdl/pac_fifo.sv]
// pac_fifo: small register queue with push/full and pop/empty sides
// no package dependency; item type and depth come from the instantiating module
module pac_fifo #(
   parameter type item_type = logic,
   parameter int  DEPTH     = 4
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type wdata,
   output logic     full,
   input  logic     pop,
   output item_type rdata,
   output logic     empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   item_type            mem_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rd_ptr_ff];

   // pointer and fill tracking
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

   // fill level never passes the depth
   assert property (@(posedge clock) disable iff (reset) count_ff <= CNT_W'(DEPTH))
      else $error("pac_fifo: fill level above depth");

endmodule

[hdl/pac_front.sv]
// pac_front: accepts vertices, tracks first/second/previous points and count
// depends on pac_pkg; feeds classified words to the job queue
module pac_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_push,
   input  logic [pac_pkg::COORD_BITS-1:0]   req_vertex_x,
   input  logic [pac_pkg::COORD_BITS-1:0]   req_vertex_y,
   input  logic                             req_last_vertex,
   output pac_pkg::wr_ctl_type              job_ctl_out,
   input  logic                             job_full,
   output pac_pkg::job_type                 job_word
);
   import pac_pkg::*;

   point_type              first_ff, first_in;
   point_type              second_ff, second_in;
   point_type              older_ff, older_in;
   point_type              prev_ff, prev_in;
   logic [COUNT_BITS-1:0]  seen_ff, seen_in;
   logic [COUNT_BITS-1:0]  seen_next;
   point_type              cur;
   logic                   accept;

   assign accept         = req_push && !job_full;
   assign cur.x          = $signed(req_vertex_x);
   assign cur.y          = $signed(req_vertex_y);
   assign seen_next      = (seen_ff == COUNT_MAX) ? seen_ff : seen_ff + 1'b1;
   assign job_ctl_out.push = accept;
   assign job_ctl_out.full = job_full;

   // classify the vertex
   always_comb begin
      job_word.cur        = cur;
      job_word.prev       = prev_ff;
      job_word.older      = older_ff;
      job_word.first      = (seen_ff == '0) ? cur : first_ff;
      job_word.second     = second_ff;
      job_word.add_cross  = (seen_ff != '0);
      job_word.test_mid   = (seen_ff >= COUNT_BITS'(2));
      job_word.test_close = req_last_vertex && (seen_ff >= COUNT_BITS'(2));
      job_word.last       = req_last_vertex;
      job_word.count      = seen_next;
      job_word.shape_ok   = (seen_next >= COUNT_MIN) && (seen_next < COUNT_MAX);
   end

   // point history; a last vertex starts a new polygon
   always_comb begin
      first_in  = first_ff;
      second_in = second_ff;
      older_in  = older_ff;
      prev_in   = prev_ff;
      seen_in   = seen_ff;
      if (accept) begin
         if (seen_ff == '0) begin
            first_in = cur;
         end
         if (seen_ff == COUNT_BITS'(1)) begin
            second_in = cur;
         end
         older_in = prev_ff;
         prev_in  = cur;
         seen_in  = req_last_vertex ? '0 : seen_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= '0;
      end else begin
         seen_ff <= seen_in;
      end
   end

   always_ff @(posedge clock) begin
      first_ff  <= first_in;
      second_ff <= second_in;
      older_ff  <= older_in;
      prev_ff   <= prev_in;
   end

   // count saturates and restarts after a last vertex
   assert property (@(posedge clock) disable iff (reset) seen_ff <= COUNT_MAX)
      else $error("pac_front: vertex count above limit");
   assert property (@(posedge clock) disable iff (reset)
      accept && req_last_vertex |=> seen_ff == '0)
      else $error("pac_front: count not cleared after last vertex");

endmodule

[hdl/pac_back.sv]
// pac_back: products, cross/dot reduction, shoelace accumulation and result build
// depends on pac_pkg; pops the job queue and pushes the result queue
module pac_back (
   input  logic                   clock,
   input  logic                   reset,
   input  pac_pkg::job_type       job_word,
   input  logic                   job_empty,
   output logic                   job_pop,
   output pac_pkg::wr_ctl_type    rsp_ctl_out,
   input  logic                   rsp_full,
   output pac_pkg::result_type    rsp_word
);
   import pac_pkg::*;

   logic advance;

   // stage 1: products
   logic                          s1_valid_ff;
   job_type                       s1_job_ff;
   logic signed [PROD_BITS-1:0]   pa_ff, pb_ff, pc_ff, pd_ff;
   logic signed [DOT_BITS-1:0]    dax_ff, day_ff, dbx_ff, dby_ff, dcx_ff, dcy_ff;
   logic signed [DIFF_BITS-1:0]   a1x, a1y, a2x, a2y, b1x, b1y, b2x, b2y;
   logic signed [DIFF_BITS-1:0]   c1x, c1y, c2x, c2y;

   // stage 2: reduced terms
   logic                          s2_valid_ff;
   logic                          s2_last_ff, s2_close_ff, s2_ok_ff;
   logic [COUNT_BITS-1:0]         s2_count_ff;
   logic signed [TERM_BITS-1:0]   s2_term_ff, term_in;
   logic                          s2_hit_ff, hit_in;
   logic signed [PROD_BITS:0]     cross_prev, cross_close;
   logic signed [DOT_BITS:0]      dot_a, dot_b, dot_c;

   // stage 3: accumulator and finished polygon
   logic signed [ACC_BITS-1:0]    acc_ff, acc_in, acc_sum;
   logic                          right_ff, right_in, right_now;
   logic                          res_valid_ff;
   logic signed [ACC_BITS-1:0]    res_sum_ff;
   logic                          res_right_ff, res_ok_ff;
   logic [COUNT_BITS-1:0]         res_count_ff;
   logic [ACC_BITS-1:0]           mag;

   assign advance = !rsp_full;
   assign job_pop = advance && !job_empty;

   // operand differences for the three dot products
   always_comb begin
      a1x = DIFF_BITS'(job_word.older.x) - DIFF_BITS'(job_word.prev.x);
      a1y = DIFF_BITS'(job_word.older.y) - DIFF_BITS'(job_word.prev.y);
      a2x = DIFF_BITS'(job_word.cur.x)   - DIFF_BITS'(job_word.prev.x);
      a2y = DIFF_BITS'(job_word.cur.y)   - DIFF_BITS'(job_word.prev.y);
      b1x = DIFF_BITS'(job_word.prev.x)  - DIFF_BITS'(job_word.cur.x);
      b1y = DIFF_BITS'(job_word.prev.y)  - DIFF_BITS'(job_word.cur.y);
      b2x = DIFF_BITS'(job_word.first.x) - DIFF_BITS'(job_word.cur.x);
      b2y = DIFF_BITS'(job_word.first.y) - DIFF_BITS'(job_word.cur.y);
      c1x = DIFF_BITS'(job_word.cur.x)   - DIFF_BITS'(job_word.first.x);
      c1y = DIFF_BITS'(job_word.cur.y)   - DIFF_BITS'(job_word.first.y);
      c2x = DIFF_BITS'(job_word.second.x) - DIFF_BITS'(job_word.first.x);
      c2y = DIFF_BITS'(job_word.second.y) - DIFF_BITS'(job_word.first.y);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= !job_empty;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_job_ff <= job_word;
         pa_ff  <= job_word.prev.x * job_word.cur.y;
         pb_ff  <= job_word.cur.x * job_word.prev.y;
         pc_ff  <= job_word.cur.x * job_word.first.y;
         pd_ff  <= job_word.first.x * job_word.cur.y;
         dax_ff <= a1x * a2x;
         day_ff <= a1y * a2y;
         dbx_ff <= b1x * b2x;
         dby_ff <= b1y * b2y;
         dcx_ff <= c1x * c2x;
         dcy_ff <= c1y * c2y;
      end
   end

   // cross terms and zero tests on dot products
   always_comb begin
      cross_prev  = (PROD_BITS + 1)'(pa_ff) - (PROD_BITS + 1)'(pb_ff);
      cross_close = (PROD_BITS + 1)'(pc_ff) - (PROD_BITS + 1)'(pd_ff);
      dot_a = (DOT_BITS + 1)'(dax_ff) + (DOT_BITS + 1)'(day_ff);
      dot_b = (DOT_BITS + 1)'(dbx_ff) + (DOT_BITS + 1)'(dby_ff);
      dot_c = (DOT_BITS + 1)'(dcx_ff) + (DOT_BITS + 1)'(dcy_ff);
      term_in = (s1_job_ff.add_cross ? TERM_BITS'(cross_prev) : '0)
              + (s1_job_ff.last ? TERM_BITS'(cross_close) : '0);
      hit_in  = (s1_job_ff.test_mid && (dot_a == '0))
             || (s1_job_ff.test_close && ((dot_b == '0) || (dot_c == '0)));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_term_ff  <= term_in;
         s2_hit_ff   <= hit_in;
         s2_last_ff  <= s1_job_ff.last;
         s2_close_ff <= s1_job_ff.test_close;
         s2_ok_ff    <= s1_job_ff.shape_ok;
         s2_count_ff <= s1_job_ff.count;
      end
   end

   // shoelace accumulation, cleared when a polygon closes
   assign acc_sum   = acc_ff + ACC_BITS'(s2_term_ff);
   assign right_now = right_ff || s2_hit_ff;

   always_comb begin
      acc_in   = acc_ff;
      right_in = right_ff;
      if (advance && s2_valid_ff) begin
         acc_in   = s2_last_ff ? '0 : acc_sum;
         right_in = s2_last_ff ? 1'b0 : right_now;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         right_ff     <= 1'b0;
         res_valid_ff <= 1'b0;
      end else begin
         acc_ff   <= acc_in;
         right_ff <= right_in;
         if (advance) begin
            res_valid_ff <= s2_valid_ff && s2_last_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         res_sum_ff   <= acc_sum;
         res_right_ff <= s2_close_ff && right_now;
         res_ok_ff    <= s2_ok_ff;
         res_count_ff <= s2_count_ff;
      end
   end

   // magnitude with saturation at the area width
   assign mag = res_sum_ff[ACC_BITS-1] ? ACC_BITS'(-res_sum_ff) : ACC_BITS'(res_sum_ff);

   always_comb begin
      rsp_word.area_doubled    = mag[ACC_BITS-1] ? '1 : mag[AREA_BITS-1:0];
      rsp_word.has_right_angle = res_right_ff;
      rsp_word.vertex_count    = res_count_ff;
      rsp_word.count_is_even   = !res_count_ff[0];
      rsp_word.shape_valid     = res_ok_ff;
   end

   assign rsp_ctl_out.push = res_valid_ff && advance;
   assign rsp_ctl_out.full = rsp_full;

   // a finished polygon holds while the result queue is full
   assert property (@(posedge clock) disable iff (reset)
      res_valid_ff && rsp_full |=> res_valid_ff && $stable(res_sum_ff))
      else $error("pac_back: pending result lost under stall");
   // accumulator restarts after a closing vertex
   assert property (@(posedge clock) disable iff (reset)
      advance && s2_valid_ff && s2_last_ff |=> acc_ff == '0 && !right_ff)
      else $error("pac_back: accumulator not cleared at polygon end");

endmodule

[hdl/polygon_area_right_angle.sv]
// polygon_area_right_angle: top level, streamed shoelace area and right-angle test
// depends on pac_pkg, pac_front, pac_fifo and pac_back
//
//  channel  ports                        handshake       moves one word of
//  -------  ---------------------------  --------------  ----------------------
//  input    req_vertex_x/y, last_vertex  req_push/full   vertex
//  result   rsp_area_doubled .. valid    rsp_pop/empty   finished polygon
//
// one vertex per clock sustained while the result queue has room; a result shows
// on rsp_* after its last vertex passes the job queue, the three back stages
// and the result queue; the accumulator is a single add stage that keeps this rate
// reset is synchronous and clears queues, counters and the accumulator
// a full result queue stalls the back part; the front keeps taking vertices
// until the four-entry job queue fills
module polygon_area_right_angle (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_push,
   output logic                             req_full,
   input  logic [pac_pkg::COORD_BITS-1:0]   req_vertex_x,
   input  logic [pac_pkg::COORD_BITS-1:0]   req_vertex_y,
   input  logic                             req_last_vertex,
   output logic                             rsp_empty,
   input  logic                             rsp_pop,
   output logic [pac_pkg::AREA_BITS-1:0]    rsp_area_doubled,
   output logic                             rsp_has_right_angle,
   output logic [pac_pkg::COUNT_BITS-1:0]   rsp_vertex_count,
   output logic                             rsp_count_is_even,
   output logic                             rsp_shape_valid
);
   import pac_pkg::*;

   wr_ctl_type  job_ctl, rsp_ctl;
   job_type     job_in_word, job_out_word;
   logic        job_full, job_empty, job_pop;
   result_type  rsp_in_word, rsp_out_word;
   logic        rsp_full;

   // front: accept and classify
   pac_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_vertex_x    (req_vertex_x),
      .req_vertex_y    (req_vertex_y),
      .req_last_vertex (req_last_vertex),
      .job_ctl_out     (job_ctl),
      .job_full        (job_full),
      .job_word        (job_in_word)
   );

   assign req_full = job_ctl.full;

   // queue between front and back
   pac_fifo #(
      .item_type (job_type),
      .DEPTH     (4)
   ) u_job_q (
      .clock (clock),
      .reset (reset),
      .push  (job_ctl.push),
      .wdata (job_in_word),
      .full  (job_full),
      .pop   (job_pop),
      .rdata (job_out_word),
      .empty (job_empty)
   );

   // back: arithmetic and accumulation
   pac_back u_back (
      .clock       (clock),
      .reset       (reset),
      .job_word    (job_out_word),
      .job_empty   (job_empty),
      .job_pop     (job_pop),
      .rsp_ctl_out (rsp_ctl),
      .rsp_full    (rsp_full),
      .rsp_word    (rsp_in_word)
   );

   // result queue
   pac_fifo #(
      .item_type (result_type),
      .DEPTH     (2)
   ) u_rsp_q (
      .clock (clock),
      .reset (reset),
      .push  (rsp_ctl.push),
      .wdata (rsp_in_word),
      .full  (rsp_full),
      .pop   (rsp_pop),
      .rdata (rsp_out_word),
      .empty (rsp_empty)
   );

   assign rsp_area_doubled    = rsp_out_word.area_doubled;
   assign rsp_has_right_angle = rsp_out_word.has_right_angle;
   assign rsp_vertex_count    = rsp_out_word.vertex_count;
   assign rsp_count_is_even   = rsp_out_word.count_is_even;
   assign rsp_shape_valid     = rsp_out_word.shape_valid;

endmodule
